// File: hw/rtl/tsu_pkg.sv
// Shared constants and types for the multi-track tone sequencer.
package tsu_pkg;

  // Default sizing of the sequencer.
  localparam int unsigned TRACKS_DEF     = 5;
  localparam int unsigned NOTE_DEPTH_DEF = 64;

  // Timer clock register.
  localparam int unsigned CLK_W = 28;
  localparam logic [CLK_W-1:0] CLK_RESET = 28'd84000000;

  // Divider operand widths.
  localparam int unsigned DIVIDEND_W = CLK_W;
  localparam int unsigned DIVISOR_W  = 16;

  // Item operation codes.
  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_LOAD   = 3'd1,
    OP_PLAY   = 3'd2,
    OP_PAUSE  = 3'd3,
    OP_RESUME = 3'd4,
    OP_STOP   = 3'd5,
    OP_MUTE   = 3'd6
  } op_e;

endpackage

// File: hw/rtl/tsu_div.sv
// Restoring serial divider, one quotient bit per cycle.
module tsu_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [tsu_pkg::DIVIDEND_W-1:0]   dividend_i,
  input  logic [tsu_pkg::DIVISOR_W-1:0]    divisor_i,
  output logic                             busy_o,
  output logic                             done_o,
  output logic [tsu_pkg::DIVIDEND_W-1:0]   quot_o
);

  localparam int unsigned NW = tsu_pkg::DIVIDEND_W;
  localparam int unsigned DW = tsu_pkg::DIVISOR_W;
  localparam int unsigned CW = $clog2(NW + 1);

  logic [NW-1:0] quo_q;
  logic [DW-1:0] rem_q;
  logic [DW-1:0] div_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q;
  logic          done_q;
  logic [DW:0]   shifted;
  logic [DW:0]   diff;
  logic          fits;

  // Trial subtraction of the divisor from the shifted remainder.
  assign shifted = {rem_q, quo_q[NW-1]};
  assign diff    = shifted - {1'b0, div_q};
  assign fits    = shifted >= {1'b0, div_q};

  // Iteration control and datapath.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      quo_q  <= '0;
      rem_q  <= '0;
      div_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CW'(NW);
      quo_q  <= dividend_i;
      rem_q  <= '0;
      div_q  <= divisor_i;
    end else if (busy_q) begin
      if (fits) begin
        rem_q <= diff[DW-1:0];
      end else begin
        rem_q <= shifted[DW-1:0];
      end
      quo_q <= {quo_q[NW-2:0], fits};
      cnt_q <= cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

// File: hw/rtl/multi_track_tone_sequencer_unit.sv
// Multi-track tone sequencer: note memory, track sequencing and voice timer settings.
// Load items and rejected items go straight to the result register; a tick scans the
// tracks and runs a voice update when a note changed; a voice update scans the tracks
// from the highest down and runs one or two serial divisions.
// Throughput: one item at a time, set by the track scan and the shared serial divider.
// Reset clears all track state, the mute flag and the voice; the note memory is not cleared.
module multi_track_tone_sequencer_unit #(
  parameter int unsigned TRACKS     = tsu_pkg::TRACKS_DEF,
  parameter int unsigned NOTE_DEPTH = tsu_pkg::NOTE_DEPTH_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [tsu_pkg::CLK_W-1:0] cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [2:0]                op_i,
  input  logic [2:0]                track_i,
  input  logic [5:0]                note_slot_i,
  input  logic [15:0]               note_freq_i,
  input  logic [15:0]               note_duration_i,
  input  logic [6:0]                note_count_i,
  input  logic                      looped_i,
  input  logic                      mute_value_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      pwm_on_o,
  output logic [15:0]               prescaler_o,
  output logic [15:0]               reload_o,
  output logic [14:0]               compare_o,
  output logic [4:0]                done_mask_o,
  output logic                      accepted_o
);

  localparam int unsigned TW    = (TRACKS > 1) ? $clog2(TRACKS) : 1;
  localparam int unsigned PW    = $clog2(NOTE_DEPTH + 1);
  localparam int unsigned DEPTH = TRACKS * NOTE_DEPTH;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned NW    = tsu_pkg::DIVIDEND_W;
  localparam int unsigned DW    = tsu_pkg::DIVISOR_W;

  typedef enum logic [2:0] {
    S_IDLE, S_TK_CHK, S_TK_EVAL, S_RF_START, S_RF_CHK, S_RF_EVAL, S_DIV, S_FINISH
  } state_e;

  state_e state_q;
  logic   second_q;

  // Per-track control registers.
  logic          playing_q [TRACKS];
  logic          loaded_q  [TRACKS];
  logic          loop_q    [TRACKS];
  logic [PW-1:0] length_q  [TRACKS];
  logic [PW-1:0] pos_q     [TRACKS];
  logic [15:0]   elapsed_q [TRACKS];

  logic [tsu_pkg::CLK_W-1:0] clk_hz_q;
  logic                      muted_q;
  logic [TW-1:0]             trk_q;
  logic [TRACKS-1:0]         done_q;
  logic                      ok_q;
  logic                      refresh_q;
  logic                      voice_on_q;
  logic [15:0]               psc_q;
  logic [15:0]               period_q;

  logic          out_valid_q;
  logic          pwm_on_q;
  logic [15:0]   prescaler_q;
  logic [15:0]   reload_q;
  logic [14:0]   compare_q;
  logic [4:0]    done_mask_q;
  logic          accepted_q;

  // Divider interface.
  logic          div_start_q;
  logic [NW-1:0] div_a_q;
  logic [DW-1:0] div_b_q;
  logic          div_busy;
  logic          div_done;
  logic [NW-1:0] div_quot;

  // Note memory.
  logic [31:0]   note_mem [DEPTH];
  logic [31:0]   rdata_q;
  logic [AW-1:0] raddr;
  logic [AW-1:0] waddr;
  logic          mem_we;

  // Current track view.
  logic          cur_playing;
  logic          cur_loop;
  logic [PW-1:0] cur_len;
  logic [PW-1:0] cur_pos;
  logic [15:0]   cur_elapsed;
  logic          cur_active;
  logic [16:0]   el_next;
  logic [PW-1:0] pos_next;

  logic          in_acc;
  logic          trk_ok;
  logic          slot_ok;
  logic [TW-1:0] in_trk;
  logic [PW-1:0] play_len;
  logic          out_free;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign trk_ok     = 32'(track_i) < TRACKS;
  assign slot_ok    = 32'(note_slot_i) < NOTE_DEPTH;
  assign in_trk     = TW'(track_i);
  assign play_len   = (32'(note_count_i) > NOTE_DEPTH) ? PW'(NOTE_DEPTH) : PW'(note_count_i);
  assign out_free   = !out_valid_q || out_ready_i;

  assign cur_playing = playing_q[trk_q];
  assign cur_loop    = loop_q[trk_q];
  assign cur_len     = length_q[trk_q];
  assign cur_pos     = pos_q[trk_q];
  assign cur_elapsed = elapsed_q[trk_q];
  assign cur_active  = cur_playing && (cur_pos < cur_len);
  assign el_next     = {1'b0, cur_elapsed} + 17'd1;
  assign pos_next    = cur_pos + PW'(1);

  // Memory addressing: track base plus note position.
  assign raddr  = AW'(AW'(trk_q) * AW'(NOTE_DEPTH)) + AW'(cur_pos);
  assign waddr  = AW'(AW'(in_trk) * AW'(NOTE_DEPTH)) + AW'(note_slot_i);
  assign mem_we = in_acc && (op_i == tsu_pkg::OP_LOAD) && trk_ok && slot_ok;

  // Note memory with registered read.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      note_mem[waddr] <= {note_duration_i, note_freq_i};
    end
    rdata_q <= note_mem[raddr];
  end

  // Shared serial divider for the period and prescaler.
  tsu_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start_q),
    .dividend_i (div_a_q),
    .divisor_i  (div_b_q),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // Sequencer state machine, track state, voice and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      second_q    <= 1'b0;
      for (int i = 0; i < TRACKS; i++) begin
        playing_q[i] <= 1'b0;
        loaded_q[i]  <= 1'b0;
        loop_q[i]    <= 1'b0;
        length_q[i]  <= '0;
        pos_q[i]     <= '0;
        elapsed_q[i] <= '0;
      end
      clk_hz_q    <= tsu_pkg::CLK_RESET;
      muted_q     <= 1'b0;
      trk_q       <= '0;
      done_q      <= '0;
      ok_q        <= 1'b0;
      refresh_q   <= 1'b0;
      voice_on_q  <= 1'b0;
      psc_q       <= '0;
      period_q    <= '0;
      div_start_q <= 1'b0;
      div_a_q     <= '0;
      div_b_q     <= '0;
      out_valid_q <= 1'b0;
      pwm_on_q    <= 1'b0;
      prescaler_q <= '0;
      reload_q    <= '0;
      compare_q   <= '0;
      done_mask_q <= '0;
      accepted_q  <= 1'b0;
    end else begin
      div_start_q <= 1'b0;
      if (cfg_we_i) begin
        clk_hz_q <= cfg_wdata_i;
      end
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        // Decode an item and apply single-track commands at once.
        S_IDLE: begin
          if (in_acc) begin
            done_q    <= '0;
            refresh_q <= 1'b0;
            ok_q      <= 1'b0;
            trk_q     <= in_trk;
            state_q   <= S_FINISH;
            unique case (op_i)
              tsu_pkg::OP_TICK: begin
                ok_q    <= 1'b1;
                trk_q   <= '0;
                state_q <= S_TK_CHK;
              end
              tsu_pkg::OP_LOAD: begin
                ok_q <= trk_ok && slot_ok;
              end
              tsu_pkg::OP_PLAY: begin
                if (trk_ok && (note_count_i != '0)) begin
                  playing_q[in_trk] <= 1'b1;
                  loaded_q[in_trk]  <= 1'b1;
                  loop_q[in_trk]    <= looped_i;
                  length_q[in_trk]  <= play_len;
                  pos_q[in_trk]     <= '0;
                  elapsed_q[in_trk] <= '0;
                  ok_q              <= 1'b1;
                  state_q           <= S_RF_START;
                end
              end
              tsu_pkg::OP_PAUSE: begin
                if (trk_ok) begin
                  playing_q[in_trk] <= 1'b0;
                  ok_q              <= 1'b1;
                  state_q           <= S_RF_START;
                end
              end
              tsu_pkg::OP_RESUME: begin
                if (trk_ok && loaded_q[in_trk]) begin
                  playing_q[in_trk] <= 1'b1;
                  ok_q              <= 1'b1;
                  state_q           <= S_RF_START;
                end
              end
              tsu_pkg::OP_STOP: begin
                if (trk_ok) begin
                  done_q[in_trk]    <= loaded_q[in_trk];
                  playing_q[in_trk] <= 1'b0;
                  loaded_q[in_trk]  <= 1'b0;
                  loop_q[in_trk]    <= 1'b0;
                  length_q[in_trk]  <= '0;
                  pos_q[in_trk]     <= '0;
                  elapsed_q[in_trk] <= '0;
                  ok_q              <= 1'b1;
                  state_q           <= S_RF_START;
                end
              end
              tsu_pkg::OP_MUTE: begin
                muted_q <= mute_value_i;
                ok_q    <= 1'b1;
                state_q <= S_RF_START;
              end
              default: begin
                ok_q <= 1'b0;
              end
            endcase
          end
        end

        // Tick: visit tracks upwards, reading the current note of active ones.
        S_TK_CHK: begin
          if (cur_active) begin
            state_q <= S_TK_EVAL;
          end else if (trk_q == TW'(TRACKS - 1)) begin
            state_q <= refresh_q ? S_RF_START : S_FINISH;
          end else begin
            trk_q <= trk_q + TW'(1);
          end
        end

        S_TK_EVAL: begin
          if (el_next >= {1'b0, rdata_q[31:16]}) begin
            refresh_q        <= 1'b1;
            elapsed_q[trk_q] <= '0;
            if (pos_next >= cur_len) begin
              done_q[trk_q] <= 1'b1;
              pos_q[trk_q]  <= '0;
              if (!cur_loop) begin
                playing_q[trk_q] <= 1'b0;
                loaded_q[trk_q]  <= 1'b0;
                length_q[trk_q]  <= '0;
              end
            end else begin
              pos_q[trk_q] <= pos_next;
            end
          end else begin
            elapsed_q[trk_q] <= el_next[15:0];
          end
          if (trk_q == TW'(TRACKS - 1)) begin
            state_q <= S_RF_START;
            if (!(el_next >= {1'b0, rdata_q[31:16]}) && !refresh_q) begin
              state_q <= S_FINISH;
            end
          end else begin
            trk_q   <= trk_q + TW'(1);
            state_q <= S_TK_CHK;
          end
        end

        // Voice update: highest active track with a sounding note wins.
        S_RF_START: begin
          if (muted_q) begin
            voice_on_q <= 1'b0;
            state_q    <= S_FINISH;
          end else begin
            trk_q   <= TW'(TRACKS - 1);
            state_q <= S_RF_CHK;
          end
        end

        S_RF_CHK: begin
          if (cur_active) begin
            state_q <= S_RF_EVAL;
          end else if (trk_q == '0) begin
            voice_on_q <= 1'b0;
            state_q    <= S_FINISH;
          end else begin
            trk_q <= trk_q - TW'(1);
          end
        end

        S_RF_EVAL: begin
          if (rdata_q[15:0] != '0) begin
            div_a_q     <= clk_hz_q;
            div_b_q     <= rdata_q[15:0];
            div_start_q <= 1'b1;
            second_q    <= 1'b0;
            state_q     <= S_DIV;
          end else if (trk_q == '0) begin
            voice_on_q <= 1'b0;
            state_q    <= S_FINISH;
          end else begin
            trk_q   <= trk_q - TW'(1);
            state_q <= S_RF_CHK;
          end
        end

        // First quotient is clock/freq; a long period divides again by prescaler+1.
        S_DIV: begin
          if (div_done) begin
            voice_on_q <= 1'b1;
            if (second_q) begin
              period_q <= div_quot[15:0];
              state_q  <= S_FINISH;
            end else if (div_quot < NW'(2)) begin
              psc_q    <= '0;
              period_q <= 16'd2;
              state_q  <= S_FINISH;
            end else if (div_quot > NW'(16'hFFFF)) begin
              psc_q       <= 16'(div_quot[NW-1:16]);
              div_a_q     <= div_quot;
              div_b_q     <= DW'(div_quot[NW-1:16]) + DW'(1);
              div_start_q <= 1'b1;
              second_q    <= 1'b1;
            end else begin
              psc_q    <= '0;
              period_q <= div_quot[15:0];
              state_q  <= S_FINISH;
            end
          end
        end

        // Present the result once the output register is free.
        S_FINISH: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            pwm_on_q    <= voice_on_q;
            prescaler_q <= voice_on_q ? psc_q : '0;
            reload_q    <= voice_on_q ? (period_q - 16'd1) : '0;
            compare_q   <= voice_on_q ? period_q[15:1] : '0;
            done_mask_q <= 5'(done_q);
            accepted_q  <= ok_q;
            state_q     <= S_IDLE;
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign pwm_on_o    = pwm_on_q;
  assign prescaler_o = prescaler_q;
  assign reload_o    = reload_q;
  assign compare_o   = compare_q;
  assign done_mask_o = done_mask_q;
  assign accepted_o  = accepted_q;

`ifndef SYNTHESIS
  // The divider is never running while a new item can be taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !div_busy)
    else $error("divider busy while idle");

  // A start always puts the divider to work on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start_q |=> div_busy)
    else $error("divider did not start");

  // A silent result carries zero timer settings.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !pwm_on_o) |->
      (prescaler_o == '0) && (reload_o == '0) && (compare_o == '0))
    else $error("timer settings on a silent result");

  // A sounding voice has a period of at least two counts.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && pwm_on_o) |-> (reload_o != '0) && (compare_o != '0))
    else $error("sounding voice with short period");
`endif

endmodule

// File: verif/multi_track_tone_sequencer_unit_tb.sv
// Self-checking testbench for the multi-track tone sequencer with a built-in sequencer predictor.
module multi_track_tone_sequencer_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NTRK = 5;
  localparam int unsigned NDEP = 64;
  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned DRAIN_CYCLES = 200;

  typedef struct packed {
    logic [2:0]  op;
    logic [2:0]  trk;
    logic [5:0]  slot;
    logic [15:0] freq;
    logic [15:0] dur;
    logic [6:0]  cnt;
    logic        lp;
    logic        mv;
  } note_cmd_t;

  typedef struct packed {
    logic        pwm_on;
    logic [15:0] prescaler;
    logic [15:0] reload;
    logic [14:0] compare;
    logic [4:0]  done_mask;
    logic        accepted;
  } voice_out_t;

  logic clk_i, rst_ni;
  logic cfg_we_i;
  logic [tsu_pkg::CLK_W-1:0] cfg_wdata_i;
  logic in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  logic [2:0] op_i, track_i;
  logic [5:0] note_slot_i;
  logic [15:0] note_freq_i, note_duration_i;
  logic [6:0] note_count_i;
  logic looped_i, mute_value_i;
  logic pwm_on_o, accepted_o;
  logic [15:0] prescaler_o, reload_o;
  logic [14:0] compare_o;
  logic [4:0] done_mask_o;

  multi_track_tone_sequencer_unit u_top (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
    .op_i(op_i), .track_i(track_i), .note_slot_i(note_slot_i),
    .note_freq_i(note_freq_i), .note_duration_i(note_duration_i),
    .note_count_i(note_count_i), .looped_i(looped_i), .mute_value_i(mute_value_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i),
    .pwm_on_o(pwm_on_o), .prescaler_o(prescaler_o), .reload_o(reload_o),
    .compare_o(compare_o), .done_mask_o(done_mask_o), .accepted_o(accepted_o)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  note_cmd_t  pending_cmds[$];
  voice_out_t expected_voice[$];
  int unsigned mismatches;
  int unsigned idle_mode;
  int unsigned stall_cycles;

  // Sequencer shadow state used for prediction.
  logic [27:0] sq_clk_hz;
  logic [31:0] sq_notes[NTRK*NDEP];
  logic        sq_playing[NTRK];
  logic        sq_loaded[NTRK];
  logic        sq_loop[NTRK];
  logic [6:0]  sq_len[NTRK];
  logic [6:0]  sq_pos[NTRK];
  logic [15:0] sq_elapsed[NTRK];
  logic        sq_muted;
  logic        vc_on;
  logic [31:0] vc_psc;
  logic [31:0] vc_period;
  logic [4:0]  sq_done;

  // Slots written so far, kept by the stimulus so that no unwritten note is ever played.
  bit          slot_written[NTRK][NDEP];

  function automatic void seq_reset();
    sq_clk_hz = tsu_pkg::CLK_RESET;
    for (int t = 0; t < NTRK; t++) begin
      sq_playing[t] = 0; sq_loaded[t] = 0; sq_loop[t] = 0;
      sq_len[t] = 0; sq_pos[t] = 0; sq_elapsed[t] = 0;
    end
    for (int i = 0; i < NTRK*NDEP; i++) sq_notes[i] = '0;
    sq_muted = 0; vc_on = 0; vc_psc = 0; vc_period = 0; sq_done = 0;
  endfunction

  // Prescaler search: raise the prescaler until the period fits in 16 bits.
  function automatic void set_voice(logic [15:0] f);
    logic [63:0] clk64, per, psc;
    clk64 = {36'd0, sq_clk_hz};
    per = clk64 / f;
    psc = 0;
    if (per < 2) per = 2;
    while (per > 65535) begin
      psc++;
      per = clk64 / (f * (psc + 1));
    end
    vc_on = 1; vc_psc = psc[31:0]; vc_period = per[31:0];
  endfunction

  // Voice goes to the highest playing track on a non-rest note.
  function automatic void arbitrate_voice();
    logic [15:0] f;
    if (!sq_muted) begin
      for (int t = NTRK-1; t >= 0; t--) begin
        if (sq_playing[t] && sq_pos[t] < sq_len[t]) begin
          f = sq_notes[t*NDEP + sq_pos[t]][15:0];
          if (f != 0) begin
            set_voice(f);
            return;
          end
        end
      end
    end
    vc_on = 0;
  endfunction

  function automatic void clear_trk(int t);
    sq_playing[t] = 0; sq_loaded[t] = 0; sq_loop[t] = 0;
    sq_len[t] = 0; sq_pos[t] = 0; sq_elapsed[t] = 0;
  endfunction

  function automatic void halt_trk(int t);
    if (sq_loaded[t]) sq_done[t] = 1'b1;
    clear_trk(t);
    arbitrate_voice();
  endfunction

  function automatic void start_note(int t);
    if (sq_pos[t] >= sq_len[t]) begin
      if (sq_loop[t]) begin
        sq_done[t] = 1'b1;
        sq_pos[t] = 0;
      end else begin
        halt_trk(t);
        return;
      end
    end
    sq_elapsed[t] = 0;
    arbitrate_voice();
  endfunction

  function automatic void advance_ms();
    logic [16:0] el;
    logic [15:0] d;
    for (int t = 0; t < NTRK; t++) begin
      if (sq_playing[t] && sq_pos[t] < sq_len[t]) begin
        el = {1'b0, sq_elapsed[t]} + 17'd1;
        d = sq_notes[t*NDEP + sq_pos[t]][31:16];
        sq_elapsed[t] = el[15:0];
        if (el >= {1'b0, d}) begin
          sq_pos[t] = sq_pos[t] + 7'd1;
          start_note(t);
        end
      end
    end
  endfunction

  function automatic voice_out_t predict_voice(note_cmd_t c);
    voice_out_t r;
    logic ok;
    logic trk_ok;
    logic [6:0] n;
    ok = 0;
    trk_ok = c.trk < NTRK;
    sq_done = 0;
    case (c.op)
      tsu_pkg::OP_TICK: begin
        advance_ms();
        ok = 1;
      end
      tsu_pkg::OP_LOAD: begin
        if (trk_ok) begin
          sq_notes[c.trk*NDEP + c.slot] = {c.dur, c.freq};
          ok = 1;
        end
      end
      tsu_pkg::OP_PLAY: begin
        if (trk_ok && c.cnt != 0) begin
          n = (c.cnt > NDEP) ? 7'(NDEP) : c.cnt;
          clear_trk(c.trk);
          sq_len[c.trk] = n;
          sq_loop[c.trk] = c.lp;
          sq_loaded[c.trk] = 1;
          sq_playing[c.trk] = 1;
          start_note(c.trk);
          ok = 1;
        end
      end
      tsu_pkg::OP_PAUSE: begin
        if (trk_ok) begin
          sq_playing[c.trk] = 0;
          arbitrate_voice();
          ok = 1;
        end
      end
      tsu_pkg::OP_RESUME: begin
        if (trk_ok && sq_loaded[c.trk]) begin
          sq_playing[c.trk] = 1;
          arbitrate_voice();
          ok = 1;
        end
      end
      tsu_pkg::OP_STOP: begin
        if (trk_ok) begin
          halt_trk(c.trk);
          ok = 1;
        end
      end
      tsu_pkg::OP_MUTE: begin
        sq_muted = c.mv;
        arbitrate_voice();
        ok = 1;
      end
      default: ok = 0;
    endcase
    r.pwm_on    = vc_on;
    r.prescaler = vc_on ? vc_psc[15:0] : '0;
    r.reload    = vc_on ? 16'(vc_period - 1) : '0;
    r.compare   = vc_on ? 15'(vc_period / 2) : '0;
    r.done_mask = sq_done;
    r.accepted  = ok;
    return r;
  endfunction

  // Stimulus helper: queue one item and note which slots have been written.
  task automatic add_cmd(input logic [2:0] op, input logic [2:0] trk, input logic [5:0] slot,
                         input logic [15:0] f, input logic [15:0] d, input logic [6:0] cnt,
                         input logic lp, input logic mv);
    note_cmd_t c;
    c = '{op: op, trk: trk, slot: slot, freq: f, dur: d, cnt: cnt, lp: lp, mv: mv};
    if (op == tsu_pkg::OP_LOAD && trk < NTRK) slot_written[trk][slot] = 1;
    pending_cmds.push_back(c);
  endtask

  function automatic logic [15:0] pick_freq();
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1: return 16'($urandom);
      2: return 16'($urandom_range(1, 8));
      default: return 16'($urandom_range(100, 5000));
    endcase
  endfunction

  function automatic logic [15:0] pick_dur();
    if ($urandom_range(0, 9) == 0) return 16'($urandom);
    return 16'($urandom_range(0, 4));
  endfunction

  // Random traffic: mostly well-formed load/play/tick sequences with some noise.
  task automatic add_random(input int unsigned num);
    int unsigned k, t, n;
    bit big_done;
    big_done = 0;
    for (k = 0; k < num; k++) begin
      t = $urandom_range(0, NTRK-1);
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7:
          add_cmd(tsu_pkg::OP_TICK, 3'($urandom), 6'($urandom), 16'($urandom),
                  16'($urandom), 7'($urandom), 1'($urandom), 1'($urandom));
        8, 9:
          add_cmd(tsu_pkg::OP_LOAD, 3'(t), 6'($urandom), pick_freq(), pick_dur(),
                  7'($urandom), 1'($urandom), 1'($urandom));
        10, 11, 12: begin
          if (!big_done && $urandom_range(0, 7) == 0) begin
            n = $urandom_range(64, 127);
            big_done = 1;
          end else begin
            n = $urandom_range(1, 6);
          end
          for (int s = 0; s < ((n > NDEP) ? NDEP : n); s++)
            if (!slot_written[t][s])
              add_cmd(tsu_pkg::OP_LOAD, 3'(t), 6'(s), pick_freq(),
                      16'($urandom_range(0, 2)), '0, 0, 0);
          add_cmd(tsu_pkg::OP_PLAY, 3'(t), 6'($urandom), 16'($urandom), 16'($urandom),
                  7'(n), 1'($urandom), 1'($urandom));
        end
        13: add_cmd(tsu_pkg::OP_PAUSE, 3'(t), 6'($urandom), 16'($urandom), 16'($urandom),
                    7'($urandom), 1'($urandom), 1'($urandom));
        14: add_cmd(tsu_pkg::OP_RESUME, 3'(t), 6'($urandom), 16'($urandom), 16'($urandom),
                    7'($urandom), 1'($urandom), 1'($urandom));
        15: add_cmd(tsu_pkg::OP_STOP, 3'(t), 6'($urandom), 16'($urandom), 16'($urandom),
                    7'($urandom), 1'($urandom), 1'($urandom));
        16: add_cmd(tsu_pkg::OP_MUTE, 3'($urandom), 6'($urandom), 16'($urandom),
                    16'($urandom), 7'($urandom), 1'($urandom), 1'($urandom));
        17: add_cmd(tsu_pkg::OP_PLAY, 3'(t), 6'($urandom), 16'($urandom), 16'($urandom),
                    7'd0, 1'($urandom), 1'($urandom));
        18: add_cmd(3'($urandom_range(1, 5)), 3'($urandom_range(5, 7)), 6'($urandom),
                    16'($urandom), 16'($urandom), 7'($urandom), 1'($urandom), 1'($urandom));
        default: add_cmd(3'd7, 3'($urandom), 6'($urandom), 16'($urandom), 16'($urandom),
                         7'($urandom), 1'($urandom), 1'($urandom));
      endcase
    end
  endtask

  // Wait for the block to go idle, then write the timer clock register.
  task automatic drain_and_config(input logic [27:0] hz);
    while (pending_cmds.size() != 0 || in_valid_i || expected_voice.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= hz;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sq_clk_hz = hz;
  endtask

  // Input driver: holds each item until it is accepted.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o)
        expected_voice.push_back(predict_voice({op_i, track_i, note_slot_i, note_freq_i,
            note_duration_i, note_count_i, looped_i, mute_value_i}));
      if (!in_valid_i || in_ready_o) begin
        if (pending_cmds.size() != 0 &&
            !((idle_mode == 0 && $urandom_range(0, 99) < 25) ||
              (idle_mode == 1 && $urandom_range(0, 99) < 62))) begin
          note_cmd_t c;
          c = pending_cmds.pop_front();
          in_valid_i      <= 1'b1;
          op_i            <= c.op;
          track_i         <= c.trk;
          note_slot_i     <= c.slot;
          note_freq_i     <= c.freq;
          note_duration_i <= c.dur;
          note_count_i    <= c.cnt;
          looped_i        <= c.lp;
          mute_value_i    <= c.mv;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare each result with the oldest expectation.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        voice_out_t got, want;
        got = '{pwm_on_o, prescaler_o, reload_o, compare_o, done_mask_o, accepted_o};
        if (expected_voice.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", got);
        end else begin
          want = expected_voice.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("expected %p got %p", want, got);
          end
        end
      end
      out_ready_i <= !((idle_mode == 0 && $urandom_range(0, 99) < 62) ||
                       (idle_mode == 1 && $urandom_range(0, 99) < 25));
    end
  end

  // Watchdog on cycles with no accepted item and no taken result.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("multi_track_tone_sequencer_unit: mismatch");
        $finish;
      end
    end
  end

  // Main sequence: reset, directed items, then random phases with register changes.
  initial begin
    mismatches = 0; stall_cycles = 0; idle_mode = 0;
    cfg_we_i = 0; cfg_wdata_i = '0;
    op_i = '0; track_i = '0; note_slot_i = '0; note_freq_i = '0; note_duration_i = '0;
    note_count_i = '0; looped_i = 0; mute_value_i = 0;
    seq_reset();
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    drain_and_config(28'd84000000);

    // Directed items: field extremes, every op, rests, rejections and restarts.
    add_cmd(tsu_pkg::OP_LOAD, 3'd0, 6'd0, 16'd440, 16'd2, '0, 0, 0);
    add_cmd(tsu_pkg::OP_LOAD, 3'd0, 6'd1, 16'd0, 16'd0, '0, 0, 0);
    add_cmd(tsu_pkg::OP_LOAD, 3'd4, 6'd63, 16'hFFFF, 16'hFFFF, '0, 0, 0);
    add_cmd(tsu_pkg::OP_LOAD, 3'd4, 6'd0, 16'd1, 16'd1, '0, 0, 0);
    add_cmd(tsu_pkg::OP_PLAY, 3'd0, 6'd0, '0, '0, 7'd2, 1, 0);
    repeat (4) add_cmd(tsu_pkg::OP_TICK, '0, '0, '0, '0, '0, 0, 0);
    add_cmd(tsu_pkg::OP_PLAY, 3'd4, 6'd0, '0, '0, 7'd1, 0, 0);
    add_cmd(tsu_pkg::OP_TICK, 3'd7, 6'd63, 16'hFFFF, 16'hFFFF, 7'h7F, 1, 1);
    add_cmd(tsu_pkg::OP_PLAY, 3'd4, 6'd0, '0, '0, 7'd0, 1, 0);
    add_cmd(tsu_pkg::OP_RESUME, 3'd3, '0, '0, '0, '0, 0, 0);
    add_cmd(tsu_pkg::OP_STOP, 3'd3, '0, '0, '0, '0, 0, 0);
    add_cmd(tsu_pkg::OP_MUTE, '0, '0, '0, '0, '0, 0, 1);
    add_cmd(tsu_pkg::OP_TICK, '0, '0, '0, '0, '0, 0, 0);
    add_cmd(tsu_pkg::OP_MUTE, '0, '0, '0, '0, '0, 0, 0);
    add_cmd(tsu_pkg::OP_PAUSE, 3'd0, '0, '0, '0, '0, 0, 0);
    add_cmd(tsu_pkg::OP_RESUME, 3'd0, '0, '0, '0, '0, 0, 0);
    add_cmd(tsu_pkg::OP_PLAY, 3'd0, '0, '0, '0, 7'd2, 0, 0);
    add_cmd(tsu_pkg::OP_STOP, 3'd0, '0, '0, '0, '0, 0, 0);
    add_cmd(tsu_pkg::OP_LOAD, 3'd7, 6'd5, 16'd9, 16'd9, '0, 0, 0);
    add_cmd(3'd7, 3'd1, '0, '0, '0, '0, 0, 0);
    add_random(20);

    drain_and_config(28'd1000000);
    idle_mode = 1;
    add_random(20);

    drain_and_config(28'd200000000);
    idle_mode = 2;
    add_random(15);

    // A slow clock below the normal range forces the short-period floor.
    drain_and_config(28'd100000);
    add_cmd(tsu_pkg::OP_LOAD, 3'd2, 6'd0, 16'hFFFF, 16'd1, '0, 0, 0);
    add_cmd(tsu_pkg::OP_PLAY, 3'd2, '0, '0, '0, 7'd1, 1, 0);
    add_cmd(tsu_pkg::OP_TICK, '0, '0, '0, '0, '0, 0, 0);
    drain_and_config(28'($urandom_range(1000000, 200000000)));
    add_random(10);

    while (pending_cmds.size() != 0 || in_valid_i || expected_voice.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("multi_track_tone_sequencer_unit: match");
    end else begin
      $display("multi_track_tone_sequencer_unit: mismatch");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/tsu_pkg.sv
hw/rtl/tsu_div.sv
hw/rtl/multi_track_tone_sequencer_unit.sv
verif/multi_track_tone_sequencer_unit_tb.sv
